// ----- rtl/shlm_pkg.sv -----
// ============================================================================
// shlm_pkg: shared types and constants of the script host leaf matcher
// Holds the host name table, the unit position width and the control struct
// that passes between the top level and the name tracker.
// ============================================================================
package shlm_pkg;

    localparam int PATH_MAX_UNITS = 512;
    localparam int POS_W          = $clog2(PATH_MAX_UNITS + 1);

    localparam int HOST_COUNT = 8;
    localparam int PROG_W     = 4;
    localparam int NAME_W     = 8 * 16;

    localparam logic [PROG_W-1:0] NAME_MISMATCH = 4'd15;
    localparam logic [15:0]       FOLD_OFFSET   = 16'd32;

    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_SLASH     = 16'h002F;
    localparam logic [15:0] CH_SPACE     = 16'h0020;
    localparam logic [15:0] CH_DOT       = 16'h002E;
    localparam logic [15:0] CH_UPPER_A   = 16'h0041;
    localparam logic [15:0] CH_UPPER_Z   = 16'h005A;
    localparam logic [15:0] CH_NUL       = 16'h0000;

    localparam logic [PROG_W-1:0] HOST_LEN [HOST_COUNT] = '{
        4'd14, 4'd8, 4'd7, 4'd11, 4'd11, 4'd9, 4'd10, 4'd8
    };

    // Control from the top level to the name tracker.
    typedef struct packed {
        logic absorb;   // apply the code unit to the match counters
        logic clear;    // return all counters to zero after this cycle
    } track_ctrl_t;

    // Host name k as a right-aligned byte string.
    function automatic logic [NAME_W-1:0] host_name(input logic [2:0] k);
        logic [NAME_W-1:0] name;
        case (k)
            3'd0:    name = NAME_W'("powershell.exe");
            3'd1:    name = NAME_W'("pwsh.exe");
            3'd2:    name = NAME_W'("cmd.exe");
            3'd3:    name = NAME_W'("wscript.exe");
            3'd4:    name = NAME_W'("cscript.exe");
            3'd5:    name = NAME_W'("mshta.exe");
            3'd6:    name = NAME_W'("python.exe");
            3'd7:    name = NAME_W'("node.exe");
            default: name = '0;
        endcase
        return name;
    endfunction

    // Character at position p (counted from the start) of host name k.
    function automatic logic [7:0] host_char(input logic [2:0] k,
                                             input logic [PROG_W-1:0] p);
        logic [NAME_W-1:0] name;
        logic [PROG_W-1:0] idx;
        name = host_name(k);
        idx  = PROG_W'(HOST_LEN[k] - p - 4'd1);
        return name[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/shlm_name_track.sv -----
// ============================================================================
// shlm_name_track: per-host match counters
// Keeps one progress counter per host name, advances all of them on one
// code unit and reports whether the updated leaf equals a host name.
// ============================================================================
module shlm_name_track
    import shlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  track_ctrl_t       ctrl,
    input  logic [15:0]       code_unit,
    output logic              hit
);

    logic [PROG_W-1:0] progress_reg  [HOST_COUNT];
    logic [PROG_W-1:0] progress_next [HOST_COUNT];
    logic [PROG_W-1:0] progress_upd  [HOST_COUNT];
    logic              all_zero;

    always_comb
    begin
        logic [15:0] unit_fold;
        logic        is_sep;
        logic        is_pad;
        unit_fold = code_unit;
        if (code_unit >= CH_UPPER_A && code_unit <= CH_UPPER_Z)
        begin
            unit_fold = code_unit + FOLD_OFFSET;
        end
        is_sep = (code_unit == CH_BACKSLASH) || (code_unit == CH_SLASH);
        is_pad = (unit_fold == CH_SPACE) || (unit_fold == CH_DOT);
        hit    = 1'b0;
        for (int k = 0; k < HOST_COUNT; k++)
        begin
            progress_upd[k] = progress_reg[k];
            if (ctrl.absorb)
            begin
                if (is_sep)
                begin
                    progress_upd[k] = '0;
                end
                else if (progress_reg[k] == NAME_MISMATCH)
                begin
                    progress_upd[k] = NAME_MISMATCH;
                end
                else if (progress_reg[k] >= HOST_LEN[k])
                begin
                    if (!is_pad)
                    begin
                        progress_upd[k] = NAME_MISMATCH;
                    end
                end
                else if (unit_fold == {8'h00, host_char(3'(k), progress_reg[k])})
                begin
                    progress_upd[k] = progress_reg[k] + 4'd1;
                end
                else
                begin
                    progress_upd[k] = NAME_MISMATCH;
                end
            end
            if (progress_upd[k] == HOST_LEN[k])
            begin
                hit = 1'b1;
            end
            progress_next[k] = ctrl.clear ? '0 : progress_upd[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HOST_COUNT; k++)
            begin
                progress_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < HOST_COUNT; k++)
            begin
                progress_reg[k] <= progress_next[k];
            end
        end
    end

    always_comb
    begin
        all_zero = 1'b1;
        for (int k = 0; k < HOST_COUNT; k++)
        begin
            if (progress_reg[k] != '0)
            begin
                all_zero = 1'b0;
            end
        end
    end

    // After a path is finished every counter starts from zero again.
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> all_zero)
        else $error("match counters not cleared after path end");

    // A counter holding a finished match stays put unless a unit is applied.
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.absorb && !ctrl.clear) |=> $stable(all_zero))
        else $error("match counters changed without a unit");

    // Without a new unit a match can only come from a counter already full.
    a_hit_source: assert property (@(posedge clk) disable iff (!rst_n)
        (hit && !ctrl.absorb) |-> !all_zero)
        else $error("match reported with all counters at zero");

endmodule

// ----- rtl/script_host_path_leaf_matcher.sv -----
// ============================================================================
// script_host_path_leaf_matcher: script host detection on a path leaf
// Streams a UTF-16 path and flags whether its final component names one of
// eight fixed script host executables.
// ============================================================================
// Usage:
//   Input channel (unit_valid / unit_stall): one transaction per 16-bit code
//   unit of the path, with last set on the final unit of the path. A
//   backslash or slash starts a new leaf, ASCII A-Z compare as lower case,
//   trailing spaces and dots of the leaf are ignored. A zero unit ends the
//   path early; later units up to last are ignored, as are units at
//   position PATH_MAX_UNITS and beyond.
//   Output channel (result_valid / result_stall): exactly one transaction
//   per path, carrying is_interpreter, issued for the unit marked last.
//   Timing: a unit is registered at acceptance; a unit that is not last is
//   applied to the match counters in the following cycle. A last unit waits
//   in the input register until the output register is free, and its result
//   then passes into the output register, which drives the output.
//   Throughput: one code unit per cycle unless the input is stalled. A
//   non-last unit drains into the eight match counters without waiting;
//   only a last unit needs the output register, so stalling the output
//   holds up the input only while a last unit waits for a free output slot.
//   Reset (rst_n low, asynchronous): counters, position and both channel
//   valid flags clear; the block is ready for a new path right away.
//   After each last unit, all path state returns to its reset value.
// ============================================================================
module script_host_path_leaf_matcher
    import shlm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        unit_valid,
    output logic        unit_stall,
    input  logic [15:0] code_unit,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        is_interpreter
);

    // Input register stage.
    logic              s1_valid_reg, s1_valid_next;
    logic [15:0]       s1_unit_reg;
    logic              s1_last_reg;

    // Path state.
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ended_reg, ended_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg;

    logic              unit_take;
    logic              out_free;
    logic              s1_go;
    logic              in_range;
    track_ctrl_t       track_ctrl;
    logic              track_hit;

    // The output slot is free when empty or being taken this cycle.
    assign out_free   = !out_valid_reg || !result_stall;
    // A non-last unit never needs the output slot.
    assign s1_go      = s1_valid_reg && (!s1_last_reg || out_free);
    assign unit_stall = s1_valid_reg && !s1_go;
    assign unit_take  = unit_valid && !unit_stall;

    assign in_range   = !ended_reg && (pos_reg < POS_W'(PATH_MAX_UNITS));

    always_comb
    begin
        s1_valid_next    = unit_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        pos_next         = pos_reg;
        ended_next       = ended_reg;
        track_ctrl       = '0;
        if (s1_go && in_range)
        begin
            pos_next = POS_W'(pos_reg + 1'b1);
            if (s1_unit_reg == CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                track_ctrl.absorb = 1'b1;
            end
        end
        if (s1_go && s1_last_reg)
        begin
            track_ctrl.clear = 1'b1;
            pos_next         = '0;
            ended_next       = 1'b0;
        end
        out_valid_next = (s1_go && s1_last_reg) ? 1'b1
                       : (result_stall ? out_valid_reg : 1'b0);
    end

    shlm_name_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (track_ctrl),
        .code_unit (s1_unit_reg),
        .hit       (track_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pos_reg       <= pos_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (unit_take)
        begin
            s1_unit_reg <= code_unit;
            s1_last_reg <= last;
        end
        if (s1_go && s1_last_reg)
        begin
            out_hit_reg <= track_hit;
        end
    end

    assign result_valid   = out_valid_reg;
    assign is_interpreter = out_hit_reg;

    // Only a last unit waiting on a full output slot holds the input.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        unit_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg && result_stall))
        else $error("input stalled without a blocked last unit");

    // Finishing a path returns position and end flag to reset values.
    a_path_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |=> (pos_reg == '0 && !ended_reg))
        else $error("path state not cleared after last unit");

    // The position saturates at the path length limit.
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(PATH_MAX_UNITS))
        else $error("unit position beyond path limit");

    // The end flag is only set by a counted zero unit.
    a_end_counted: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> (pos_reg != '0))
        else $error("path end flag without counted unit");

endmodule
